>>> rtl/core/chemical_phase_partitioning_defines.svh
// assertion macros shared by the partitioning block
`ifndef CHEMICAL_PHASE_PARTITIONING_DEFINES_SVH
`define CHEMICAL_PHASE_PARTITIONING_DEFINES_SVH

// same-cycle implication
`define CPP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CPP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/cpp_pkg.sv
package cpp_pkg;
	localparam int NUM_SOLIDS = 4;
	localparam int NS_EFF = (NUM_SOLIDS < 1) ? 1 : ((NUM_SOLIDS > 4) ? 4 : NUM_SOLIDS);
	localparam int SOL_W = (NS_EFF > 1) ? $clog2(NS_EFF) : 1;
	localparam int CNT_W = $clog2(NS_EFF + 1);

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_CARBON_BASIS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SORPTION_COEF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BINDING_COEF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_CONC = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_TABLE = 3'd4;

	localparam logic [63:0] Q16_ONE = 64'd65536;
	localparam logic [63:0] PHI_ONE = 64'd1 << 30;
	localparam logic [63:0] BIG = 64'd1 << 62;
	localparam logic [63:0] LOW32 = 64'hFFFF_FFFF;
	localparam logic [63:0] GRAV_SCALE = 64'd1000000;
	localparam logic [63:0] VOL_SCALE = 64'd1 << 26;

	typedef enum logic [2:0] {
		MDV_IDLE,
		MDV_MUL,
		MDV_CHK,
		MDV_DIV,
		MDV_DONE
	} cpp_mdv_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SG,
		ST_VOL,
		ST_BASIS,
		ST_PHI,
		ST_P,
		ST_Y,
		ST_X,
		ST_BCONC,
		ST_BP,
		ST_BTERM,
		ST_DENOM,
		ST_FP,
		ST_RS,
		ST_BOUND,
		ST_EMIT
	} cpp_state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] d;
	} cpp_mdv_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] q;
	} cpp_mdv_rsp_t;

	function automatic logic [63:0] sat_add(logic [63:0] x, logic [63:0] y);
		logic [64:0] s;
		s = {1'b0, x} + {1'b0, y};
		return (s > {1'b0, BIG}) ? BIG : s[63:0];
	endfunction
endpackage

>>> rtl/core/cpp_if.sv
interface cpp_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] solid_conc;
	logic [16:0] carbon_fraction;
	logic [31:0] doc_conc;
	logic [16:0] doc_fraction;
	logic [16:0] layer_porosity;
	logic        in_water_column;
	modport source (output valid, mode, solid_conc, carbon_fraction, doc_conc,
		doc_fraction, layer_porosity, in_water_column, input ready);
	modport sink (input valid, mode, solid_conc, carbon_fraction, doc_conc,
		doc_fraction, layer_porosity, in_water_column, output ready);
endinterface

interface cpp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  solid_index;
	logic [16:0] particulate_fraction;
	logic [16:0] bound_fraction;
	logic [16:0] dissolved_fraction;
	logic        last;
	modport source (output valid, solid_index, particulate_fraction, bound_fraction,
		dissolved_fraction, last, input ready);
	modport sink (input valid, solid_index, particulate_fraction, bound_fraction,
		dissolved_fraction, last, output ready);
endinterface

interface cpp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/chemical_phase_partitioning.sv
// Chemical phase partitioning for one grid cell. Send one solid beat (mode 0) per solid
// type in order, then a close beat (mode 1); the close beat yields one result beat per
// solid type, the final one flagged last. All arithmetic goes through a single bit-serial
// multiply-divide unit, 64 multiply steps plus, unless the result saturates, 64 divide
// steps per operation. A solid beat takes three operations; a close beat takes six to
// twenty-one, then sends its result beats, one per cycle while the result side is ready.
// One beat is worked at a time; input ready is high only while the block is idle.
// Configuration writes are taken every cycle and must only be issued while the block is idle.
`include "chemical_phase_partitioning_defines.svh"

module chemical_phase_partitioning
	import cpp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cpp_in_if.sink    in_item,
	cpp_out_if.source result,
	cpp_cfg_if.sink   cfg
);
	// configuration registers
	logic        carbon_q;
	logic [31:0] sorp_q, bind_q, nux_q;
	logic [63:0] gravity_q;

	// latched input beat
	logic        water_q;
	logic [31:0] conc_q, doc_q;
	logic [16:0] cfrac_q, dfrac_q, lpor_q;

	// cell state
	logic [31:0] basis_q [NS_EFF];
	logic [31:0] vsum_q;
	logic [CNT_W-1:0] scnt_q;

	// close-beat working registers
	logic [63:0] x_q [NS_EFF];
	logic [30:0] phi_q;
	logic [63:0] sgm_q, p_q, y_q, bconc_q, bp_q, bterm_q, denom_q, sumx_q, sumfp_q;
	logic [16:0] bound_q, diss_q;
	logic [SOL_W-1:0] idx_q;
	logic        launched_q;

	// output register
	logic        ov_q, olast_q;
	logic [1:0]  oidx_q;
	logic [16:0] opart_q, obound_q, odiss_q;

	cpp_state_t state_q, state_d;
	cpp_mdv_req_t mdv_req;
	cpp_mdv_rsp_t mdv_rsp;

	logic        in_fire, emit_fire, op_state, skip, done_now, idx_last;
	logic [63:0] direct, res, sg_sel, sumfp_next, vol_sum, m_basis;
	logic [30:0] phi_calc;
	logic [SOL_W-1:0] scnt_idx;
	logic [16:0] bound_sat;
	logic [17:0] bsum;

	cpp_muldiv u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.req(mdv_req),
		.rsp(mdv_rsp)
	);

	assign scnt_idx = scnt_q[SOL_W-1:0];
	assign idx_last = (idx_q == SOL_W'(NS_EFF - 1));
	assign sg_sel = {48'd0, 16'(gravity_q >> {scnt_idx, 4'd0})};
	assign res = skip ? direct : mdv_rsp.q;
	assign done_now = op_state && (skip || mdv_rsp.done);
	assign sumfp_next = sumfp_q + res;
	assign vol_sum = res + {32'd0, vsum_q};
	assign m_basis = {32'd0, basis_q[idx_q]};
	// bound fraction clamped at one, then the sum that the dissolved part is left from
	assign bound_sat = (res > Q16_ONE) ? 17'd65536 : res[16:0];
	assign bsum = {1'b0, bound_sat} + 18'(sumfp_q);

	// porosity in Q1.30
	always_comb begin
		if (water_q)
			phi_calc = ({32'd0, vsum_q} >= PHI_ONE) ? 31'd0 : 31'(PHI_ONE - {32'd0, vsum_q});
		else
			phi_calc = ({47'd0, lpor_q} >= Q16_ONE) ? 31'(PHI_ONE) : {lpor_q, 14'd0};
	end

	// operand select for the shared unit; skip finishes an op with a fixed value
	always_comb begin
		mdv_req = '0;
		skip = 1'b0;
		direct = '0;
		op_state = 1'b1;
		case (state_q)
			ST_SG: begin
				mdv_req.a = sg_sel;
				mdv_req.b = GRAV_SCALE;
				mdv_req.d = 64'd1;
			end
			ST_VOL: begin
				mdv_req.a = {32'd0, conc_q};
				mdv_req.b = VOL_SCALE;
				mdv_req.d = sgm_q;
			end
			ST_BASIS: begin
				mdv_req.a = {32'd0, conc_q};
				mdv_req.b = carbon_q ? {47'd0, cfrac_q} : Q16_ONE;
				mdv_req.d = Q16_ONE;
			end
			ST_P: begin
				mdv_req.a = {32'd0, sorp_q};
				mdv_req.b = PHI_ONE;
				mdv_req.d = {33'd0, phi_q};
			end
			ST_Y: begin
				// zero porosity: sorption coefficient is infinite
				skip = (phi_q == 31'd0);
				if (m_basis == 64'd0) direct = '0;
				else direct = water_q ? {32'd0, nux_q} : BIG;
				mdv_req.a = m_basis;
				mdv_req.b = p_q;
				mdv_req.d = Q16_ONE;
			end
			ST_X: begin
				// particle interaction saturation
				mdv_req.a = y_q;
				mdv_req.b = {32'd0, nux_q};
				mdv_req.d = {32'd0, nux_q} + y_q;
				skip = (mdv_req.d == 64'd0);
			end
			ST_BCONC: begin
				mdv_req.a = {32'd0, doc_q};
				mdv_req.b = carbon_q ? {47'd0, dfrac_q} : Q16_ONE;
				mdv_req.d = Q16_ONE;
			end
			ST_BP: begin
				skip = !water_q || (phi_q == 31'd0);
				mdv_req.a = {32'd0, carbon_q ? sorp_q : bind_q};
				mdv_req.b = PHI_ONE;
				mdv_req.d = {33'd0, phi_q};
			end
			ST_BTERM: begin
				// binding is zeroed at zero water porosity, uncorrected in sediment
				skip = water_q && (phi_q == 31'd0);
				mdv_req.a = water_q ? bp_q : {32'd0, carbon_q ? sorp_q : bind_q};
				mdv_req.b = bconc_q;
				mdv_req.d = Q16_ONE;
			end
			ST_FP: begin
				mdv_req.a = x_q[idx_q];
				mdv_req.b = Q16_ONE;
				mdv_req.d = denom_q;
			end
			ST_RS: begin
				// renormalize when the particulate sum goes above one
				mdv_req.a = x_q[idx_q];
				mdv_req.b = Q16_ONE;
				mdv_req.d = sumfp_q;
			end
			ST_BOUND: begin
				mdv_req.a = bterm_q;
				mdv_req.b = Q16_ONE;
				mdv_req.d = denom_q;
			end
			default: op_state = 1'b0;
		endcase
		mdv_req.start = op_state && !skip && !launched_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_item.mode) state_d = ST_PHI;
					else if (scnt_q < CNT_W'(NS_EFF)) state_d = ST_SG;
				end
			end
			ST_SG: if (done_now) state_d = ST_VOL;
			ST_VOL: if (done_now) state_d = ST_BASIS;
			ST_BASIS: if (done_now) state_d = ST_IDLE;
			ST_PHI: state_d = (phi_calc != 31'd0) ? ST_P : ST_Y;
			ST_P: if (done_now) state_d = ST_Y;
			ST_Y: begin
				if (done_now) begin
					if (water_q && phi_q != 31'd0) state_d = ST_X;
					else if (idx_last) state_d = ST_BCONC;
				end
			end
			ST_X: if (done_now) state_d = idx_last ? ST_BCONC : ST_Y;
			ST_BCONC: if (done_now) state_d = ST_BP;
			ST_BP: if (done_now) state_d = ST_BTERM;
			ST_BTERM: if (done_now) state_d = ST_DENOM;
			ST_DENOM: state_d = ST_FP;
			ST_FP: begin
				if (done_now && idx_last)
					state_d = (sumfp_next > Q16_ONE) ? ST_RS : ST_BOUND;
			end
			ST_RS: if (done_now && idx_last) state_d = ST_BOUND;
			ST_BOUND: if (done_now) state_d = ST_EMIT;
			ST_EMIT: if (emit_fire && idx_last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_item.ready = (state_q == ST_IDLE);
		in_fire = in_item.valid && in_item.ready;
		emit_fire = (state_q == ST_EMIT) && (!ov_q || result.ready);
		cfg.ready = 1'b1;
		result.valid = ov_q;
		result.solid_index = oidx_q;
		result.particulate_fraction = opart_q;
		result.bound_fraction = obound_q;
		result.dissolved_fraction = odiss_q;
		result.last = olast_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			launched_q <= 1'b0;
			ov_q <= 1'b0;
			carbon_q <= 1'b0;
			sorp_q <= '0;
			bind_q <= '0;
			nux_q <= 32'd65536;
			gravity_q <= '0;
			vsum_q <= '0;
			scnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (mdv_req.start) launched_q <= 1'b1;
			else if (mdv_rsp.done) launched_q <= 1'b0;
			if (emit_fire) ov_q <= 1'b1;
			else if (result.ready) ov_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_CARBON_BASIS: carbon_q <= cfg.data[0];
					CFG_SORPTION_COEF: sorp_q <= cfg.data[31:0];
					CFG_BINDING_COEF: bind_q <= cfg.data[31:0];
					CFG_SATURATION_CONC: nux_q <= cfg.data[31:0];
					CFG_GRAVITY_TABLE: gravity_q <= cfg.data;
					default: ;
				endcase
			end
			if (state_q == ST_VOL && done_now)
				vsum_q <= (vol_sum > LOW32) ? 32'hFFFF_FFFF : vol_sum[31:0];
			if (state_q == ST_BASIS && done_now)
				scnt_q <= scnt_q + CNT_W'(1);
			// close beat done: next cell starts empty
			if (emit_fire && idx_last) begin
				vsum_q <= '0;
				scnt_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			conc_q <= in_item.solid_conc;
			cfrac_q <= in_item.carbon_fraction;
			doc_q <= in_item.doc_conc;
			dfrac_q <= in_item.doc_fraction;
			lpor_q <= in_item.layer_porosity;
			water_q <= in_item.in_water_column;
		end
		case (state_q)
			ST_SG: if (done_now) sgm_q <= res;
			ST_BASIS: begin
				if (done_now) basis_q[scnt_idx] <= (res > LOW32) ? 32'hFFFF_FFFF : res[31:0];
			end
			ST_PHI: begin
				phi_q <= phi_calc;
				sumx_q <= '0;
				idx_q <= '0;
			end
			ST_P: if (done_now) p_q <= res;
			ST_Y: begin
				if (done_now) begin
					if (water_q && phi_q != 31'd0) begin
						y_q <= res;
					end else begin
						x_q[idx_q] <= res;
						sumx_q <= sat_add(sumx_q, res);
						idx_q <= idx_last ? '0 : idx_q + SOL_W'(1);
					end
				end
			end
			ST_X: begin
				if (done_now) begin
					x_q[idx_q] <= res;
					sumx_q <= sat_add(sumx_q, res);
					idx_q <= idx_last ? '0 : idx_q + SOL_W'(1);
				end
			end
			ST_BCONC: if (done_now) bconc_q <= res;
			ST_BP: if (done_now) bp_q <= res;
			ST_BTERM: if (done_now) bterm_q <= res;
			ST_DENOM: begin
				denom_q <= sat_add(sat_add(Q16_ONE, bterm_q), sumx_q);
				sumfp_q <= '0;
				idx_q <= '0;
			end
			ST_FP: begin
				if (done_now) begin
					x_q[idx_q] <= res;
					sumfp_q <= sumfp_next;
					idx_q <= idx_last ? '0 : idx_q + SOL_W'(1);
				end
			end
			ST_RS: begin
				if (done_now) begin
					x_q[idx_q] <= res;
					idx_q <= idx_last ? '0 : idx_q + SOL_W'(1);
					if (idx_last) sumfp_q <= Q16_ONE;
				end
			end
			ST_BOUND: begin
				if (done_now) begin
					bound_q <= bound_sat;
					// dissolved fraction, clamped at zero
					diss_q <= ((sumfp_q > Q16_ONE) || (bsum >= 18'd65536)) ? 17'd0
						: 17'(18'd65536 - bsum);
				end
				idx_q <= '0;
			end
			ST_EMIT: begin
				if (emit_fire) begin
					oidx_q <= 2'(idx_q);
					opart_q <= x_q[idx_q][16:0];
					obound_q <= bound_q;
					odiss_q <= diss_q;
					olast_q <= idx_last;
					idx_q <= idx_last ? '0 : idx_q + SOL_W'(1);
					// unrecorded solids of the next cell count as zero
					if (idx_last) begin
						for (int k = 0; k < NS_EFF; k++) basis_q[k] <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	`CPP_ASSERT_IMP(a_cnt_range, 1'b1, scnt_q <= CNT_W'(NS_EFF), "solid counter overran")
	`CPP_ASSERT_IMP(a_start_free, mdv_req.start, !mdv_rsp.busy, "muldiv started while busy")
	`CPP_ASSERT_IMP(a_last_idx, result.valid && result.last,
		result.solid_index == 2'(NS_EFF - 1), "last flag on wrong solid")
	`CPP_ASSERT_NXT(a_close_busy, in_fire && in_item.mode, state_q != ST_IDLE,
		"close beat did not start work")
endmodule

>>> rtl/core/cpp_muldiv.sv
// bit-serial min(BIG, floor(a*b/d)): shift-add multiply then restoring divide
module cpp_muldiv
	import cpp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cpp_mdv_req_t req,
	output cpp_mdv_rsp_t rsp
);
	cpp_mdv_state_t state_q, state_d;
	logic [63:0] a_q, b_q, d_q, hi_q, lo_q;
	logic [5:0]  cnt_q;
	logic [127:0] mul_sum;
	logic [64:0]  rem_sh;
	logic         rem_ge;
	logic         sat_chk;

	assign mul_sum = {hi_q[62:0], lo_q, 1'b0} + (b_q[63] ? {64'd0, a_q} : 128'd0);
	assign rem_sh = {hi_q, lo_q[63]};
	assign rem_ge = rem_sh[64] | (rem_sh[63:0] >= d_q);
	assign sat_chk = (d_q == 64'd0) || (hi_q >= d_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			MDV_IDLE: if (req.start) state_d = MDV_MUL;
			MDV_MUL: if (cnt_q == 6'd63) state_d = MDV_CHK;
			MDV_CHK: state_d = sat_chk ? MDV_DONE : MDV_DIV;
			MDV_DIV: if (cnt_q == 6'd63) state_d = MDV_DONE;
			MDV_DONE: state_d = MDV_IDLE;
			default: state_d = MDV_IDLE;
		endcase
	end

	always_comb begin
		rsp.busy = (state_q != MDV_IDLE);
		rsp.done = (state_q == MDV_DONE);
		rsp.q = (lo_q > BIG) ? BIG : lo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MDV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MDV_IDLE: begin
				if (req.start) begin
					a_q <= req.a;
					b_q <= req.b;
					d_q <= req.d;
					hi_q <= '0;
					lo_q <= '0;
					cnt_q <= '0;
				end
			end
			MDV_MUL: begin
				hi_q <= mul_sum[127:64];
				lo_q <= mul_sum[63:0];
				b_q <= {b_q[62:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
			end
			MDV_CHK: begin
				cnt_q <= '0;
				if (sat_chk) lo_q <= BIG;
			end
			MDV_DIV: begin
				hi_q <= rem_ge ? (rem_sh[63:0] - d_q) : rem_sh[63:0];
				lo_q <= {lo_q[62:0], rem_ge};
				cnt_q <= cnt_q + 6'd1;
			end
			default: ;
		endcase
	end
endmodule
